FILE: hw/rtl/qualified_edge_time_detector_assert.svh
// Assertion macros for the qualified edge time detector.
// Included by the top level; needs no other file.
`ifndef QUALIFIED_EDGE_TIME_DETECTOR_ASSERT_SVH
`define QUALIFIED_EDGE_TIME_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define QED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define QED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/qed_pkg.sv
// Shared types and constants of the qualified edge time detector.
// No dependencies.
package qed_pkg;

  // Configuration register indexes; the index port can also name unused slots.
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SELECT_MASK  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_START = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TIME    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RISING_EDGE  = 3'd3;

  // Reset values before truncation to the configured widths.
  localparam logic [63:0] SELECT_MASK_RESET = 64'd8;
  localparam logic [63:0] HOLD_TIME_RESET   = 64'd200000;

  // Per-beat decision flags from the evaluation stage.
  typedef struct packed {
    logic emit;   // a result beat is produced
    logic found;  // result carries a confirmed edge
  } qed_flags_t;

  // Run status, exposed for checking.
  typedef struct packed {
    logic pending;
    logic done;
  } qed_status_t;

endpackage

FILE: hw/rtl/qed_cfg.sv
// Configuration registers of the qualified edge time detector.
// Depends on qed_pkg.
module qed_cfg import qed_pkg::*; #(
  parameter int unsigned TIME_BITS = 40,
  parameter int unsigned TAG_BITS  = 32,
  localparam int unsigned DATA_BITS = (TIME_BITS > TAG_BITS) ? TIME_BITS : TAG_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  logic [CFG_IDX_BITS-1:0] idx_i,
  input  logic [DATA_BITS-1:0]    data_i,
  output logic [TAG_BITS-1:0]     select_mask_o,
  output logic [TIME_BITS-1:0]    window_start_o,
  output logic [TIME_BITS-1:0]    hold_time_o,
  output logic                    rising_edge_o
);

  logic [TAG_BITS-1:0]  select_mask_q;
  logic [TIME_BITS-1:0] window_start_q;
  logic [TIME_BITS-1:0] hold_time_q;
  logic                 rising_edge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      select_mask_q  <= SELECT_MASK_RESET[TAG_BITS-1:0];
      window_start_q <= '0;
      hold_time_q    <= HOLD_TIME_RESET[TIME_BITS-1:0];
      rising_edge_q  <= 1'b1;
    end else if (we_i) begin
      case (idx_i)
        REG_SELECT_MASK:  select_mask_q  <= data_i[TAG_BITS-1:0];
        REG_WINDOW_START: window_start_q <= data_i[TIME_BITS-1:0];
        REG_HOLD_TIME:    hold_time_q    <= data_i[TIME_BITS-1:0];
        REG_RISING_EDGE:  rising_edge_q  <= data_i[0];
        default: ;
      endcase
    end
  end

  assign select_mask_o  = select_mask_q;
  assign window_start_o = window_start_q;
  assign hold_time_o    = hold_time_q;
  assign rising_edge_o  = rising_edge_q;

endmodule

FILE: hw/rtl/qed_in_reg.sv
// Input register of the qualified edge time detector.
// No package dependencies.
module qed_in_reg #(
  parameter int unsigned TIME_BITS = 40,
  parameter int unsigned TAG_BITS  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [TIME_BITS-1:0] event_time_i,
  input  logic [TAG_BITS-1:0]  tag_bits_i,
  input  logic                 last_event_i,
  input  logic                 advance_i,
  output logic                 valid_o,
  output logic [TIME_BITS-1:0] event_time_o,
  output logic [TAG_BITS-1:0]  tag_bits_o,
  output logic                 last_event_o
);

  logic                 valid_q;
  logic [TIME_BITS-1:0] time_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic                 last_q;
  logic                 load;

  // Hold while the held beat cannot move on.
  assign in_stall_o = valid_q && !advance_i;
  assign load       = !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      time_q <= event_time_i;
      tag_q  <= tag_bits_i;
      last_q <= last_event_i;
    end
  end

  assign valid_o      = valid_q;
  assign event_time_o = time_q;
  assign tag_bits_o   = tag_q;
  assign last_event_o = last_q;

endmodule

FILE: hw/rtl/qed_eval.sv
// Run state and per-beat decision of the qualified edge time detector.
// Depends on qed_pkg.
module qed_eval import qed_pkg::*; #(
  parameter int unsigned TIME_BITS  = 40,
  parameter int unsigned TAG_BITS   = 32,
  parameter int unsigned SKIP_ITEMS = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic [TIME_BITS-1:0] event_time_i,
  input  logic [TAG_BITS-1:0]  tag_bits_i,
  input  logic                 last_event_i,
  input  logic [TAG_BITS-1:0]  select_mask_i,
  input  logic [TIME_BITS-1:0] window_start_i,
  input  logic [TIME_BITS-1:0] hold_time_i,
  input  logic                 rising_edge_i,
  output qed_flags_t           flags_o,
  output logic [TIME_BITS-1:0] edge_time_o,
  output qed_status_t          status_o
);

  localparam int unsigned CNT_BITS = (SKIP_ITEMS > 0) ? $clog2(SKIP_ITEMS + 1) : 1;
  localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(SKIP_ITEMS);

  logic                 prev_level_q, prev_level_d;
  logic [CNT_BITS-1:0]  count_q, count_d;
  logic                 pending_q, pending_d;
  logic [TIME_BITS-1:0] cand_time_q, cand_time_d;
  logic                 done_q, done_d;

  logic                 level;
  logic [TIME_BITS-1:0] diff;
  logic                 confirm;
  logic                 cancel;
  logic                 arm;

  assign level = |(tag_bits_i & select_mask_i);
  assign diff  = event_time_i - cand_time_q;

  // Time check first, then the level check.
  assign confirm = !done_q && pending_q && (event_time_i > cand_time_q)
                   && (diff > hold_time_i);
  assign cancel  = !done_q && pending_q && !confirm && (level != rising_edge_i);
  assign arm     = !done_q && !pending_q && (count_q >= CNT_MAX)
                   && (event_time_i > window_start_i)
                   && (level == rising_edge_i) && (prev_level_q != rising_edge_i);

  always_comb begin
    prev_level_d = level;
    count_d      = (count_q < CNT_MAX) ? count_q + CNT_BITS'(1) : count_q;
    pending_d    = arm || (pending_q && !confirm && !cancel);
    cand_time_d  = arm ? event_time_i : cand_time_q;
    done_d       = done_q || confirm;
    if (last_event_i) begin
      // Last beat of the run: drop everything.
      prev_level_d = 1'b0;
      count_d      = '0;
      pending_d    = 1'b0;
      cand_time_d  = '0;
      done_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= 1'b0;
      count_q      <= '0;
      pending_q    <= 1'b0;
      cand_time_q  <= '0;
      done_q       <= 1'b0;
    end else if (advance_i) begin
      prev_level_q <= prev_level_d;
      count_q      <= count_d;
      pending_q    <= pending_d;
      cand_time_q  <= cand_time_d;
      done_q       <= done_d;
    end
  end

  assign flags_o.emit  = confirm || (last_event_i && !done_q);
  assign flags_o.found = confirm;
  assign edge_time_o   = confirm ? cand_time_q : '0;

  assign status_o.pending = pending_q;
  assign status_o.done    = done_q;

endmodule

FILE: hw/rtl/qed_out_reg.sv
// Result register of the qualified edge time detector.
// Depends on qed_pkg.
module qed_out_reg import qed_pkg::*; #(
  parameter int unsigned TIME_BITS = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  qed_flags_t           flags_i,
  input  logic [TIME_BITS-1:0] edge_time_i,
  output logic                 can_take_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 edge_found_o,
  output logic [TIME_BITS-1:0] edge_time_o
);

  logic                 valid_q;
  logic                 found_q;
  logic [TIME_BITS-1:0] time_q;

  assign can_take_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_take_o) begin
      valid_q <= advance_i && flags_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_take_o && advance_i && flags_i.emit) begin
      found_q <= flags_i.found;
      time_q  <= edge_time_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign edge_found_o = found_q;
  assign edge_time_o  = time_q;

endmodule

FILE: hw/rtl/qualified_edge_time_detector.sv
// Qualified edge time detector: top level.
// Depends on qed_pkg, qed_cfg, qed_in_reg, qed_eval, qed_out_reg and the assert header.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event beat: event_time_i,
//   tag_bits_i, last_event_i. The watched level is the OR of tag_bits_i under the
//   select mask. After the first SKIP_ITEMS beats of a run, a beat later than the
//   window start that completes the chosen edge arms a candidate; a later beat
//   more than hold_time past it confirms it, a beat back at the old level drops
//   it. The beat with last_event_i set ends the run and clears the run state.
//   Output channel (out_valid_o / out_stall_i) carries at most one beat per input
//   beat: edge_found_o = 1 with the candidate time, or 0 with time zero when the
//   run ends unconfirmed.
//   Path: a beat is held in the input register, evaluated by the single evaluation
//   stage (one subtract and compares) and its result lands in the result register.
//   Throughput is one beat per cycle while out_stall_i does not hold the output.
//   Stall: a stalled result holds the result register; the input register then
//   holds its beat and in_stall_o rises, so nothing is lost or repeated.
//   Reset: configuration returns to mask 8, window start 0, hold 200000 ticks, rising
//   edge; run state and both registers are emptied. The user must write configuration
//   (cfg_we_i, cfg_idx_i, cfg_data_i) only while idle; the block does not enforce it.
`include "qualified_edge_time_detector_assert.svh"

module qualified_edge_time_detector import qed_pkg::*; #(
  parameter int unsigned TIME_BITS  = 40,
  parameter int unsigned TAG_BITS   = 32,
  parameter int unsigned SKIP_ITEMS = 3,
  localparam int unsigned DATA_BITS = (TIME_BITS > TAG_BITS) ? TIME_BITS : TAG_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [DATA_BITS-1:0]    cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [TIME_BITS-1:0]    event_time_i,
  input  logic [TAG_BITS-1:0]     tag_bits_i,
  input  logic                    last_event_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    edge_found_o,
  output logic [TIME_BITS-1:0]    edge_time_o
);

  logic [TAG_BITS-1:0]  select_mask;
  logic [TIME_BITS-1:0] window_start;
  logic [TIME_BITS-1:0] hold_time;
  logic                 rising_edge;

  logic                 held_valid;
  logic [TIME_BITS-1:0] held_time;
  logic [TAG_BITS-1:0]  held_tag;
  logic                 held_last;

  logic                 out_can_take;
  logic                 advance;
  qed_flags_t           flags;
  logic [TIME_BITS-1:0] result_time;
  qed_status_t          status;

  // Evaluate the held beat whenever the result register can take its outcome.
  assign advance = held_valid && out_can_take;

  qed_cfg #(
    .TIME_BITS(TIME_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .we_i          (cfg_we_i),
    .idx_i         (cfg_idx_i),
    .data_i        (cfg_data_i),
    .select_mask_o (select_mask),
    .window_start_o(window_start),
    .hold_time_o   (hold_time),
    .rising_edge_o (rising_edge)
  );

  qed_in_reg #(
    .TIME_BITS(TIME_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .event_time_i(event_time_i),
    .tag_bits_i  (tag_bits_i),
    .last_event_i(last_event_i),
    .advance_i   (advance),
    .valid_o     (held_valid),
    .event_time_o(held_time),
    .tag_bits_o  (held_tag),
    .last_event_o(held_last)
  );

  qed_eval #(
    .TIME_BITS (TIME_BITS),
    .TAG_BITS  (TAG_BITS),
    .SKIP_ITEMS(SKIP_ITEMS)
  ) u_eval (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .event_time_i  (held_time),
    .tag_bits_i    (held_tag),
    .last_event_i  (held_last),
    .select_mask_i (select_mask),
    .window_start_i(window_start),
    .hold_time_i   (hold_time),
    .rising_edge_i (rising_edge),
    .flags_o       (flags),
    .edge_time_o   (result_time),
    .status_o      (status)
  );

  qed_out_reg #(
    .TIME_BITS(TIME_BITS)
  ) u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .flags_i     (flags),
    .edge_time_i (result_time),
    .can_take_o  (out_can_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .edge_found_o(edge_found_o),
    .edge_time_o (edge_time_o)
  );

  // A not-found beat always carries time zero.
  `QED_ASSERT_NOW(a_notfound_zero, clk_i, rst_ni, out_valid_o && !edge_found_o, edge_time_o == '0, "not-found result with nonzero time")
  // A finished run never keeps a candidate.
  `QED_ASSERT_NOW(a_done_no_pending, clk_i, rst_ni, status.done, !status.pending, "candidate pending after run done")
  // A confirmation that does not end the run marks it done.
  `QED_ASSERT_NEXT(a_confirm_done, clk_i, rst_ni, advance && flags.found && !held_last, status.done, "confirmed edge did not finish the run")
  // An evaluated beat that emits lands in the result register.
  `QED_ASSERT_NEXT(a_emit_lands, clk_i, rst_ni, advance && flags.emit, out_valid_o, "emitted result lost")

endmodule
